// ----- rtl/assert_macros.svh -----
// Assertion macros for the ordered array unit.
// Assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OAIDS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define OAIDS_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define OAIDS_ASSERT(lbl, clk, rstn, prop)
`define OAIDS_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ----- rtl/oaids_pkg.sv -----
// Shared constants, codes and types for the ordered array unit.
// No dependencies.
package oaids_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 6;   // indexes one of CAPACITY entries
  localparam int CNT_W    = 7;   // holds 0..CAPACITY
  localparam int POS_W    = 8;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 3;

  localparam logic [OP_W-1:0] OP_INS_START = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_END   = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_END   = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_START = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
  localparam logic [OP_W-1:0] OP_SEARCH    = 3'd6;

  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BEYOND   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NEGATIVE = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd4;
  localparam logic [STAT_W-1:0] STAT_MISSING  = 3'd5;

  // Broadcast to every cell in the chain
  typedef struct packed {
    logic              ins;
    logic              del;
    logic              srch;
    logic [IDX_W-1:0]  at;
    logic [DATA_W-1:0] word;
    logic [CNT_W-1:0]  count;
  } cell_ctrl_t;

endpackage

// ----- rtl/oaids_cell.sv -----
// One entry of the ordered array: shifts from either neighbour, loads, compares.
// Depends on oaids_pkg.
module oaids_cell (
  input  logic                           clk_i,
  input  logic [oaids_pkg::IDX_W-1:0]    idx_i,
  input  oaids_pkg::cell_ctrl_t          ctrl_i,
  input  logic [oaids_pkg::DATA_W-1:0]   left_i,
  input  logic [oaids_pkg::DATA_W-1:0]   right_i,
  output logic [oaids_pkg::DATA_W-1:0]   entry_o,
  output logic                           match_o
);

  logic [oaids_pkg::DATA_W-1:0] entry_d, entry_q;
  logic                         match_d, match_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (idx_i > ctrl_i.at) begin
        entry_d = left_i;
      end else if (idx_i == ctrl_i.at) begin
        entry_d = ctrl_i.word;
      end
    end else if (ctrl_i.del) begin
      if (idx_i >= ctrl_i.at) begin
        entry_d = right_i;
      end
    end
  end

  // only entries below the fill count may match
  assign match_d = ctrl_i.srch && (entry_q == ctrl_i.word) &&
                   ({1'b0, idx_i} < ctrl_i.count);

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// ----- rtl/oaids_ffs.sv -----
// Find-first encoder over the registered match bits of the cell chain.
// Depends on oaids_pkg.
module oaids_ffs (
  input  logic [oaids_pkg::CAPACITY-1:0] match_i,
  output logic                           hit_o,
  output logic [oaids_pkg::IDX_W-1:0]    idx_o
);

  always_comb begin
    idx_o = '0;
    // walk down so the lowest set bit wins
    for (int k = oaids_pkg::CAPACITY - 1; k >= 0; k--) begin
      if (match_i[k]) begin
        idx_o = oaids_pkg::IDX_W'(k);
      end
    end
  end

  assign hit_o = |match_i;

endmodule

// ----- rtl/ordered_array_insert_delete_search_unit.sv -----
// Ordered array with insert, delete and search: top level.
// Depends on oaids_pkg, oaids_cell, oaids_ffs and assert_macros.svh.
//
//   channel | direction | handshake                 | fields
//   --------+-----------+---------------------------+---------------------------------
//   in      | input     | in_valid_i / in_ready_o   | op_i, position_i, value_i
//   out     | output    | out_valid_o / out_ready_i | status_o, found_at_o, fill_count_o
//
// Inserts and deletes shift or load the cells from the position on at the accepting edge.
// In a search the cells compare and register a match bit, then the find-first encoder picks
// the lowest index. A new command is taken while no search is pending and the output register
// is free or being emptied. Reset clears the fill count and the handshake; entries stay
// unknown. A stalled output holds the result and blocks the next command until it is taken.
`include "assert_macros.svh"
module ordered_array_insert_delete_search_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [oaids_pkg::OP_W-1:0]      op_i,
  input  logic signed [oaids_pkg::POS_W-1:0] position_i,
  input  logic signed [oaids_pkg::DATA_W-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [oaids_pkg::STAT_W-1:0]    status_o,
  output logic [oaids_pkg::IDX_W-1:0]     found_at_o,
  output logic [oaids_pkg::CNT_W-1:0]     fill_count_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SRCH = 1'b1;
  localparam int   CMP_W   = (oaids_pkg::POS_W > oaids_pkg::CNT_W) ?
                             oaids_pkg::POS_W : oaids_pkg::CNT_W;

  logic                               state_q;
  logic                               out_valid_q;
  logic [oaids_pkg::CNT_W-1:0]        count_q, count_d;
  logic [oaids_pkg::STAT_W-1:0]       status_q, status_d;
  logic [oaids_pkg::IDX_W-1:0]        found_q, found_d;
  logic [oaids_pkg::CNT_W-1:0]        fill_q;
  logic [oaids_pkg::STAT_W-1:0]       cmd_stat;
  logic                               accept, out_free, go_search, finish_search, load_out;
  logic                               empty, full, neg, ins_beyond, del_beyond;
  logic [CMP_W-1:0]                   pos_cmp, cnt_cmp;
  oaids_pkg::cell_ctrl_t              ctrl;
  logic [oaids_pkg::DATA_W-1:0]       ent [oaids_pkg::CAPACITY];
  logic [oaids_pkg::CAPACITY-1:0]     match;
  logic                               hit;
  logic [oaids_pkg::IDX_W-1:0]        hit_idx;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign empty      = (count_q == '0);
  assign full       = (count_q == oaids_pkg::CNT_W'(oaids_pkg::CAPACITY));
  assign neg        = position_i[oaids_pkg::POS_W-1];
  assign pos_cmp    = CMP_W'($unsigned(position_i));
  assign cnt_cmp    = CMP_W'(count_q);
  assign ins_beyond = !neg && (pos_cmp > cnt_cmp);
  assign del_beyond = !neg && (pos_cmp >= cnt_cmp);

  // decode the command, flag it, and drive the cell chain
  always_comb begin
    cmd_stat   = oaids_pkg::STAT_OK;
    count_d    = count_q;
    go_search  = 1'b0;
    ctrl       = '0;
    ctrl.word  = value_i;
    ctrl.count = count_q;
    unique case (op_i)
      oaids_pkg::OP_INS_START: begin
        cmd_stat = full ? oaids_pkg::STAT_FULL : oaids_pkg::STAT_OK;
        ctrl.at  = '0;
        ctrl.ins = !full;
      end
      oaids_pkg::OP_INS_END: begin
        cmd_stat = full ? oaids_pkg::STAT_FULL : oaids_pkg::STAT_OK;
        ctrl.at  = count_q[oaids_pkg::IDX_W-1:0];
        ctrl.ins = !full;
      end
      oaids_pkg::OP_INS_AT: begin
        if (ins_beyond) cmd_stat = oaids_pkg::STAT_BEYOND;
        else if (neg)   cmd_stat = oaids_pkg::STAT_NEGATIVE;
        else if (full)  cmd_stat = oaids_pkg::STAT_FULL;
        ctrl.at  = position_i[oaids_pkg::IDX_W-1:0];
        ctrl.ins = (cmd_stat == oaids_pkg::STAT_OK);
      end
      oaids_pkg::OP_DEL_END: begin
        cmd_stat = empty ? oaids_pkg::STAT_EMPTY : oaids_pkg::STAT_OK;
      end
      oaids_pkg::OP_DEL_START: begin
        cmd_stat = empty ? oaids_pkg::STAT_EMPTY : oaids_pkg::STAT_OK;
        ctrl.at  = '0;
        ctrl.del = !empty;
      end
      oaids_pkg::OP_DEL_AT: begin
        if (del_beyond) cmd_stat = oaids_pkg::STAT_BEYOND;
        else if (neg)   cmd_stat = oaids_pkg::STAT_NEGATIVE;
        ctrl.at  = position_i[oaids_pkg::IDX_W-1:0];
        ctrl.del = (cmd_stat == oaids_pkg::STAT_OK);
      end
      oaids_pkg::OP_SEARCH: begin
        cmd_stat  = empty ? oaids_pkg::STAT_EMPTY : oaids_pkg::STAT_OK;
        go_search = !empty;
        ctrl.srch = accept && !empty;
      end
      default: begin
      end
    endcase
    if (op_i != oaids_pkg::OP_SEARCH && cmd_stat == oaids_pkg::STAT_OK) begin
      if (op_i == oaids_pkg::OP_INS_START || op_i == oaids_pkg::OP_INS_END ||
          op_i == oaids_pkg::OP_INS_AT) begin
        count_d = count_q + 1'b1;
      end else if (op_i == oaids_pkg::OP_DEL_END || op_i == oaids_pkg::OP_DEL_START ||
                   op_i == oaids_pkg::OP_DEL_AT) begin
        count_d = count_q - 1'b1;
      end
    end
    // only move the chain on an accepted transaction
    ctrl.ins = ctrl.ins && accept;
    ctrl.del = ctrl.del && accept;
  end

  for (genvar k = 0; k < oaids_pkg::CAPACITY; k++) begin : g_cell
    logic [oaids_pkg::DATA_W-1:0] left, right;
    if (k == 0) begin : g_first
      assign left = value_i;
    end else begin : g_left
      assign left = ent[k-1];
    end
    if (k == oaids_pkg::CAPACITY - 1) begin : g_last
      assign right = ent[k];
    end else begin : g_right
      assign right = ent[k+1];
    end
    oaids_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (oaids_pkg::IDX_W'(k)),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .entry_o (ent[k]),
      .match_o (match[k])
    );
  end

  oaids_ffs u_ffs (
    .match_i (match),
    .hit_o   (hit),
    .idx_o   (hit_idx)
  );

  assign finish_search = (state_q == ST_SRCH) && out_free;
  assign load_out      = (accept && !go_search) || finish_search;

  always_comb begin
    if (finish_search) begin
      status_d = hit ? oaids_pkg::STAT_OK : oaids_pkg::STAT_MISSING;
      found_d  = hit ? hit_idx : '0;
    end else begin
      status_d = cmd_stat;
      found_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (load_out) out_valid_q <= 1'b1;
      if (accept) begin
        count_q <= count_d;
        if (go_search) state_q <= ST_SRCH;
      end
      if (finish_search) state_q <= ST_IDLE;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q <= status_d;
      found_q  <= found_d;
      fill_q   <= finish_search ? count_q : count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign found_at_o   = found_q;
  assign fill_count_o = fill_q;

  `OAIDS_NEVER(a_count_cap, clk_i, rst_ni, count_q > oaids_pkg::CNT_W'(oaids_pkg::CAPACITY))
  `OAIDS_ASSERT(a_fill_tracks, clk_i, rst_ni, out_valid_o |-> fill_count_o == count_q)
  `OAIDS_ASSERT(a_search_enters, clk_i, rst_ni, (accept && go_search) |=> state_q == ST_SRCH)
  `OAIDS_ASSERT(a_cmd_result, clk_i, rst_ni, (accept && !go_search) |=> out_valid_o)

endmodule

// ----- verif/ordered_array_insert_delete_search_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for ordered_array_insert_delete_search_unit.
// Depends on oaids_pkg and the unit's RTL; each result is checked against a typed value or a
// shadow copy of the table that is updated as each command transaction is accepted.
module ordered_array_insert_delete_search_unit_tb;

  localparam logic [oaids_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int REPORT_LIMIT  = 10;
  localparam int HOLD_CYCLES   = 250;

  typedef struct packed {
    logic [oaids_pkg::OP_W-1:0]          op;
    logic signed [oaids_pkg::POS_W-1:0]  position;
    logic signed [oaids_pkg::DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [oaids_pkg::STAT_W-1:0] status;
    logic [oaids_pkg::IDX_W-1:0]  found_at;
    logic [oaids_pkg::CNT_W-1:0]  fill_count;
  } result_t;

  typedef struct packed {
    cmd_t    cmd;
    logic    hand_set;
    result_t want;
  } row_t;

  logic                                clk_i;
  logic                                rst_ni      = 1'b0;
  logic                                in_valid_i  = 1'b0;
  logic                                in_ready_o;
  logic [oaids_pkg::OP_W-1:0]          op_i        = '0;
  logic signed [oaids_pkg::POS_W-1:0]  position_i  = '0;
  logic signed [oaids_pkg::DATA_W-1:0] value_i     = '0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  logic [oaids_pkg::STAT_W-1:0]        status_o;
  logic [oaids_pkg::IDX_W-1:0]         found_at_o;
  logic [oaids_pkg::CNT_W-1:0]         fill_count_o;

  logic [oaids_pkg::DATA_W-1:0] shadow_words [oaids_pkg::CAPACITY];
  int                           shadow_count = 0;
  result_t                      pending_results [$];
  int                           mismatches = 0;
  int                           sent = 0;
  logic                         sender_quiet = 1'b0;

  // Expected result typed in where it is plain; the rest come from the shadow table
  row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{oaids_pkg::OP_DEL_END,   8'sd0,   32'h0000_0000},
      1'b1, '{oaids_pkg::STAT_EMPTY,    6'd0, 7'd0}},
    '{'{oaids_pkg::OP_DEL_START, 8'sd0,   32'h0000_0000},
      1'b1, '{oaids_pkg::STAT_EMPTY,    6'd0, 7'd0}},
    '{'{oaids_pkg::OP_DEL_AT,    8'sd0,   32'h0000_0000},
      1'b1, '{oaids_pkg::STAT_BEYOND,   6'd0, 7'd0}},
    '{'{oaids_pkg::OP_DEL_AT,    8'sh80,  32'h0000_0000},
      1'b1, '{oaids_pkg::STAT_NEGATIVE, 6'd0, 7'd0}},
    '{'{oaids_pkg::OP_SEARCH,    8'sd0,   32'h0000_0000},
      1'b1, '{oaids_pkg::STAT_EMPTY,    6'd0, 7'd0}},
    '{'{oaids_pkg::OP_INS_AT,    8'sd1,   32'h0000_0005},
      1'b1, '{oaids_pkg::STAT_BEYOND,   6'd0, 7'd0}},
    '{'{oaids_pkg::OP_INS_AT,    -8'sd1,  32'h0000_0005},
      1'b1, '{oaids_pkg::STAT_NEGATIVE, 6'd0, 7'd0}},
    '{'{OP_UNUSED,               8'sd127, 32'hffff_ffff},
      1'b1, '{oaids_pkg::STAT_OK,       6'd0, 7'd0}},
    '{'{oaids_pkg::OP_INS_AT,    8'sd0,   32'h8000_0000},
      1'b1, '{oaids_pkg::STAT_OK,       6'd0, 7'd1}},
    '{'{oaids_pkg::OP_INS_END,   8'sd0,   32'h7fff_ffff},
      1'b1, '{oaids_pkg::STAT_OK,       6'd0, 7'd2}},
    '{'{oaids_pkg::OP_INS_START, 8'sd0,   32'h0000_0000},
      1'b1, '{oaids_pkg::STAT_OK,       6'd0, 7'd3}},
    '{'{oaids_pkg::OP_INS_AT,    8'sd3,   32'hffff_ffff},
      1'b1, '{oaids_pkg::STAT_OK,       6'd0, 7'd4}},
    '{'{oaids_pkg::OP_INS_AT,    8'sd127, 32'h1234_5678},
      1'b1, '{oaids_pkg::STAT_BEYOND,   6'd0, 7'd4}},
    '{'{oaids_pkg::OP_SEARCH,    8'sd0,   32'h7fff_ffff},
      1'b0, '{oaids_pkg::STAT_OK,       6'd0, 7'd0}},
    '{'{oaids_pkg::OP_SEARCH,    8'sd0,   32'h8000_0000},
      1'b0, '{oaids_pkg::STAT_OK,       6'd0, 7'd0}},
    '{'{oaids_pkg::OP_SEARCH,    8'sd0,   32'h0000_0001},
      1'b1, '{oaids_pkg::STAT_MISSING,  6'd0, 7'd4}},
    '{'{oaids_pkg::OP_INS_AT,    8'sd2,   32'h7fff_ffff},
      1'b0, '{oaids_pkg::STAT_OK,       6'd0, 7'd0}},
    '{'{oaids_pkg::OP_SEARCH,    8'sd0,   32'h7fff_ffff},
      1'b0, '{oaids_pkg::STAT_OK,       6'd0, 7'd0}},
    '{'{oaids_pkg::OP_DEL_AT,    8'sd5,   32'h0000_0000},
      1'b1, '{oaids_pkg::STAT_BEYOND,   6'd0, 7'd5}},
    '{'{oaids_pkg::OP_DEL_AT,    -8'sd1,  32'h0000_0000},
      1'b1, '{oaids_pkg::STAT_NEGATIVE, 6'd0, 7'd5}},
    '{'{oaids_pkg::OP_DEL_AT,    8'sd1,   32'h0000_0000},
      1'b0, '{oaids_pkg::STAT_OK,       6'd0, 7'd0}},
    '{'{oaids_pkg::OP_DEL_START, 8'sd0,   32'h0000_0000},
      1'b0, '{oaids_pkg::STAT_OK,       6'd0, 7'd0}},
    '{'{oaids_pkg::OP_DEL_END,   8'sd0,   32'h0000_0000},
      1'b0, '{oaids_pkg::STAT_OK,       6'd0, 7'd0}},
    '{'{oaids_pkg::OP_SEARCH,    8'sd0,   32'hffff_ffff},
      1'b0, '{oaids_pkg::STAT_OK,       6'd0, 7'd0}},
    '{'{OP_UNUSED,               8'sh80,  32'h0000_0000},
      1'b0, '{oaids_pkg::STAT_OK,       6'd0, 7'd0}}
  };

  ordered_array_insert_delete_search_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .found_at_o   (found_at_o),
    .fill_count_o (fill_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [oaids_pkg::STAT_W-1:0] place_word(int at,
                                                              logic [oaids_pkg::DATA_W-1:0] word);
    if (shadow_count >= oaids_pkg::CAPACITY) return oaids_pkg::STAT_FULL;
    for (int k = shadow_count; k > at; k--) shadow_words[k] = shadow_words[k-1];
    shadow_words[at] = word;
    shadow_count++;
    return oaids_pkg::STAT_OK;
  endfunction

  function automatic void drop_word(int at);
    for (int k = at; k + 1 < shadow_count; k++) shadow_words[k] = shadow_words[k+1];
    shadow_count--;
  endfunction

  // Advance the shadow table by one command and return the result it should give
  function automatic result_t apply_command(cmd_t c);
    result_t r;
    int      p;
    r = '0;
    r.status = oaids_pkg::STAT_OK;
    p = c.position;
    case (c.op)
      oaids_pkg::OP_INS_START: r.status = place_word(0, c.value);
      oaids_pkg::OP_INS_END:   r.status = place_word(shadow_count, c.value);
      oaids_pkg::OP_INS_AT: begin
        if (p > shadow_count) r.status = oaids_pkg::STAT_BEYOND;
        else if (p < 0) r.status = oaids_pkg::STAT_NEGATIVE;
        else r.status = place_word(p, c.value);
      end
      oaids_pkg::OP_DEL_END: begin
        if (shadow_count == 0) r.status = oaids_pkg::STAT_EMPTY;
        else shadow_count--;
      end
      oaids_pkg::OP_DEL_START: begin
        if (shadow_count == 0) r.status = oaids_pkg::STAT_EMPTY;
        else drop_word(0);
      end
      oaids_pkg::OP_DEL_AT: begin
        if (p >= shadow_count) r.status = oaids_pkg::STAT_BEYOND;
        else if (p < 0) r.status = oaids_pkg::STAT_NEGATIVE;
        else drop_word(p);
      end
      oaids_pkg::OP_SEARCH: begin
        if (shadow_count == 0) begin
          r.status = oaids_pkg::STAT_EMPTY;
        end else begin
          r.status = oaids_pkg::STAT_MISSING;
          for (int k = 0; k < shadow_count; k++) begin
            if (shadow_words[k] == c.value) begin
              r.status = oaids_pkg::STAT_OK;
              r.found_at = oaids_pkg::IDX_W'(k);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    r.fill_count = oaids_pkg::CNT_W'(shadow_count);
    return r;
  endfunction

  // Mostly in range, otherwise anywhere in the signed byte
  function automatic logic [oaids_pkg::POS_W-1:0] pick_position(int upper);
    if ($urandom_range(0, 9) < 7)
      return oaids_pkg::POS_W'($urandom_range(0, (upper < 0) ? 0 : upper));
    return oaids_pkg::POS_W'($urandom_range(0, 255));
  endfunction

  // Small values repeat often, so searches meet duplicates
  function automatic logic [oaids_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1, 2: return oaids_pkg::DATA_W'(int'($urandom_range(0, 15)) - 8);
      3:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic cmd_t make_command(int kind);
    cmd_t c;
    c.op       = oaids_pkg::OP_W'(kind);
    c.position = oaids_pkg::POS_W'($urandom_range(0, 255));
    c.value    = $urandom();
    case (c.op)
      oaids_pkg::OP_INS_START, oaids_pkg::OP_INS_END: c.value = pick_word();
      oaids_pkg::OP_INS_AT: begin
        c.position = pick_position(shadow_count);
        c.value    = pick_word();
      end
      oaids_pkg::OP_DEL_AT: c.position = pick_position(shadow_count - 1);
      oaids_pkg::OP_SEARCH: begin
        if (shadow_count > 0 && $urandom_range(0, 9) < 6)
          c.value = shadow_words[$urandom_range(0, shadow_count - 1)];
        else
          c.value = pick_word();
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c, input logic hand_set, input result_t want);
    int      gap;
    result_t predicted;
    if (sent % 64 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
    gap = sender_quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= c.op;
    position_i <= c.position;
    value_i    <= c.value;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predicted = apply_command(c);
    pending_results.push_back(hand_set ? want : predicted);
    sent++;
  endtask

  initial begin : stimulus
    int phase;
    int kind;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_cmd(directed_rows[i].cmd, directed_rows[i].hand_set, directed_rows[i].want);

    while (sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      phase = $urandom_range(0, 9);
      if (phase < 3) begin
        // fill to capacity, then push against the full table
        while (shadow_count < oaids_pkg::CAPACITY)
          send_cmd(make_command($urandom_range(oaids_pkg::OP_INS_START, oaids_pkg::OP_INS_AT)),
                   1'b0, '0);
        repeat ($urandom_range(1, 3))
          send_cmd(make_command($urandom_range(oaids_pkg::OP_INS_START, oaids_pkg::OP_INS_AT)),
                   1'b0, '0);
      end else if (phase < 6) begin
        // drain to empty, then try deleting from nothing
        while (shadow_count > 0)
          send_cmd(make_command($urandom_range(oaids_pkg::OP_DEL_END, oaids_pkg::OP_DEL_AT)),
                   1'b0, '0);
        repeat ($urandom_range(1, 3))
          send_cmd(make_command($urandom_range(oaids_pkg::OP_DEL_END, oaids_pkg::OP_DEL_AT)),
                   1'b0, '0);
      end else if (phase < 9) begin
        repeat (40) begin
          kind = $urandom_range(oaids_pkg::OP_INS_START, oaids_pkg::OP_SEARCH + 3);
          if (kind > oaids_pkg::OP_SEARCH) kind = oaids_pkg::OP_SEARCH;
          send_cmd(make_command(kind), 1'b0, '0);
        end
      end else begin
        repeat (12)
          send_cmd(make_command($urandom_range(oaids_pkg::OP_INS_START, OP_UNUSED)), 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin : result_check
    int      stall;
    int      taken;
    logic    quiet;
    result_t got;
    result_t want;
    taken = 0;
    quiet = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (taken % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      stall = quiet ? 0 : $urandom_range(0, 7);
      // hold off for a long stretch so the unit backs up and stalls its input
      if (taken == 400 || taken == 1200) stall = HOLD_CYCLES;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.status     = status_o;
      got.found_at   = found_at_o;
      got.fill_count = fill_count_o;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result: status %0d found_at %0d count %0d",
                   $time, got.status, got.found_at, got.fill_count);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.found_at !== want.found_at ||
            got.fill_count !== want.fill_count) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: result %0d: want status %0d found_at %0d count %0d, got %0d %0d %0d",
                     $time, taken, want.status, want.found_at, want.fill_count,
                     got.status, got.found_at, got.fill_count);
        end
      end
      taken++;
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/oaids_pkg.sv
rtl/oaids_cell.sv
rtl/oaids_ffs.sv
rtl/ordered_array_insert_delete_search_unit.sv
verif/ordered_array_insert_delete_search_unit_tb.sv
